[sv/scan_backoff_policy_top_assert.svh]
// Assertion macros shared by the scan backoff policy RTL.
`ifndef SCAN_BACKOFF_POLICY_TOP_ASSERT_SVH
`define SCAN_BACKOFF_POLICY_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/sbp_pkg.sv]
// ----------------------------------------------------------------------------
// sbp_pkg
// Types and codes shared by the scan backoff policy modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sbp_pkg;

    localparam int NOW_W    = 48;
    localparam int CNT_W    = 16;
    localparam int CFG_W    = 32;
    localparam int RUN_W    = 8;
    localparam int CFG_IDXW = 3;

    localparam logic [1:0] MODE_REQUEST  = 2'd0;
    localparam logic [1:0] MODE_SUSPEND  = 2'd1;
    localparam logic [1:0] MODE_EVALUATE = 2'd2;
    localparam logic [1:0] MODE_OBSERVE  = 2'd3;

    localparam logic [1:0] V_IDLE    = 2'd0;
    localparam logic [1:0] V_SCAN    = 2'd1;
    localparam logic [1:0] V_EXPIRED = 2'd2;
    localparam logic [1:0] V_WAIT    = 2'd3;

    localparam logic [1:0] O_SETTLED  = 2'd0;
    localparam logic [1:0] O_CONTINUE = 2'd1;
    localparam logic [1:0] O_NONE     = 2'd2;

    localparam logic [CFG_IDXW-1:0] CFG_MAX_LIFETIME   = 3'd0;
    localparam logic [CFG_IDXW-1:0] CFG_BACKOFF_AFTER  = 3'd1;
    localparam logic [CFG_IDXW-1:0] CFG_NORMAL_IVAL    = 3'd2;
    localparam logic [CFG_IDXW-1:0] CFG_BACKOFF_IVAL   = 3'd3;
    localparam logic [CFG_IDXW-1:0] CFG_MAX_EMPTY      = 3'd4;

    localparam logic [CFG_W-1:0] RST_MAX_LIFETIME  = 32'd60000;
    localparam logic [CFG_W-1:0] RST_BACKOFF_AFTER = 32'd10000;
    localparam logic [CFG_W-1:0] RST_NORMAL_IVAL   = 32'd1000;
    localparam logic [CFG_W-1:0] RST_BACKOFF_IVAL  = 32'd5000;
    localparam logic [RUN_W-1:0] RST_MAX_EMPTY     = 8'd3;

    typedef struct packed {
        logic [1:0]       mode;
        logic [NOW_W-1:0] now_ms;
        logic [CNT_W-1:0] seen_count;
        logic [CNT_W-1:0] follow_count;
    } t_item;

    typedef struct packed {
        logic [1:0] verdict;
        logic       armed;
    } t_result;

endpackage

`default_nettype wire

[sv/sbp_in_if.sv]
// ----------------------------------------------------------------------------
// sbp_in_if
// Input channel: valid/ready handshake carrying one policy item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbp_in_if import sbp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       mode;
    logic [NOW_W-1:0] now_ms;
    logic [CNT_W-1:0] seen_count;
    logic [CNT_W-1:0] follow_count;

    modport source (output valid, mode, now_ms, seen_count, follow_count,
                    input ready);
    modport sink   (input valid, mode, now_ms, seen_count, follow_count,
                    output ready);
endinterface

`default_nettype wire

[sv/sbp_out_if.sv]
// ----------------------------------------------------------------------------
// sbp_out_if
// Output channel: valid/ready handshake carrying one policy result.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    logic       armed;

    modport source (output valid, verdict, armed, input ready);
    modport sink   (input valid, verdict, armed, output ready);
endinterface

`default_nettype wire

[sv/sbp_core.sv]
// ----------------------------------------------------------------------------
// sbp_core
// Configuration registers, scan window state and the per-item decision logic.
// ----------------------------------------------------------------------------
`default_nettype none

module sbp_core import sbp_pkg::*; #(
    parameter int TIME_BITS = 48
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CFG_IDXW-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]    i_cfg_data,
    input  wire logic                i_step,
    input  wire t_item               i_item,
    output t_result                  o_result
);

    localparam int TW = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;

    logic [CFG_W-1:0] r_max_life;
    logic [CFG_W-1:0] r_bo_after;
    logic [CFG_W-1:0] r_norm_ival;
    logic [CFG_W-1:0] r_bo_ival;
    logic [RUN_W-1:0] r_max_empty;

    logic             r_armed,      n_armed;
    logic             r_start_vld,  n_start_vld;
    logic [TW-1:0]    r_start_time, n_start_time;
    logic             r_last_vld,   n_last_vld;
    logic [TW-1:0]    r_last_time,  n_last_time;
    logic [RUN_W-1:0] r_run,        n_run;

    logic [TW-1:0]    w_now;
    logic [TW-1:0]    w_age;
    logic [TW-1:0]    w_since;
    logic [TW-1:0]    w_ival;
    logic [RUN_W-1:0] w_run_inc;
    logic [1:0]       w_verdict;

    assign w_now     = i_item.now_ms[TW-1:0];
    assign w_age     = w_now - r_start_time;
    assign w_since   = w_now - r_last_time;
    assign w_ival    = (w_age >= TW'(r_bo_after)) ? TW'(r_bo_ival) : TW'(r_norm_ival);
    assign w_run_inc = (r_run != {RUN_W{1'b1}}) ? r_run + RUN_W'(1) : r_run;

    always_comb begin
        n_armed      = r_armed;
        n_start_vld  = r_start_vld;
        n_start_time = r_start_time;
        n_last_vld   = r_last_vld;
        n_last_time  = r_last_time;
        n_run        = r_run;
        w_verdict    = V_IDLE;
        if (i_step) begin
            case (i_item.mode)
                MODE_REQUEST: begin
                    if (!r_armed) begin
                        n_armed      = 1'b1;
                        n_start_vld  = 1'b0;
                        n_start_time = '0;
                        n_last_vld   = 1'b0;
                        n_last_time  = '0;
                        n_run        = '0;
                    end
                end
                MODE_SUSPEND: begin
                    n_armed      = 1'b0;
                    n_start_vld  = 1'b0;
                    n_start_time = '0;
                    n_last_vld   = 1'b0;
                    n_last_time  = '0;
                    n_run        = '0;
                end
                MODE_EVALUATE: begin
                    if (!r_armed) begin
                        w_verdict = V_IDLE;
                    end else if (!r_start_vld || (w_now < r_start_time) ||
                                 (r_last_vld && (w_now < r_last_time))) begin
                        n_start_vld  = 1'b1;
                        n_start_time = w_now;
                        n_last_vld   = 1'b1;
                        n_last_time  = w_now;
                        n_run        = '0;
                        w_verdict    = V_SCAN;
                    end else if (w_age >= TW'(r_max_life)) begin
                        n_armed      = 1'b0;
                        n_start_vld  = 1'b0;
                        n_start_time = '0;
                        n_last_vld   = 1'b0;
                        n_last_time  = '0;
                        n_run        = '0;
                        w_verdict    = V_EXPIRED;
                    end else if (!r_last_vld || (w_since >= w_ival)) begin
                        n_last_vld  = 1'b1;
                        n_last_time = w_now;
                        w_verdict   = V_SCAN;
                    end else begin
                        w_verdict = V_WAIT;
                    end
                end
                default: begin
                    if (!r_armed) begin
                        w_verdict = O_SETTLED;
                    end else if (i_item.seen_count == '0) begin
                        if (w_run_inc >= r_max_empty) begin
                            n_armed      = 1'b0;
                            n_start_vld  = 1'b0;
                            n_start_time = '0;
                            n_last_vld   = 1'b0;
                            n_last_time  = '0;
                            n_run        = '0;
                            w_verdict    = O_NONE;
                        end else begin
                            n_run     = w_run_inc;
                            w_verdict = O_CONTINUE;
                        end
                    end else if (i_item.follow_count == '0) begin
                        n_armed      = 1'b0;
                        n_start_vld  = 1'b0;
                        n_start_time = '0;
                        n_last_vld   = 1'b0;
                        n_last_time  = '0;
                        n_run        = '0;
                        w_verdict    = O_SETTLED;
                    end else begin
                        n_run     = '0;
                        w_verdict = O_CONTINUE;
                    end
                end
            endcase
        end
    end

    assign o_result.verdict = w_verdict;
    assign o_result.armed   = n_armed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_life  <= RST_MAX_LIFETIME;
            r_bo_after  <= RST_BACKOFF_AFTER;
            r_norm_ival <= RST_NORMAL_IVAL;
            r_bo_ival   <= RST_BACKOFF_IVAL;
            r_max_empty <= RST_MAX_EMPTY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_LIFETIME:  r_max_life  <= i_cfg_data;
                CFG_BACKOFF_AFTER: r_bo_after  <= i_cfg_data;
                CFG_NORMAL_IVAL:   r_norm_ival <= i_cfg_data;
                CFG_BACKOFF_IVAL:  r_bo_ival   <= i_cfg_data;
                CFG_MAX_EMPTY:     r_max_empty <= i_cfg_data[RUN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed      <= 1'b0;
            r_start_vld  <= 1'b0;
            r_start_time <= '0;
            r_last_vld   <= 1'b0;
            r_last_time  <= '0;
            r_run        <= '0;
        end else begin
            r_armed      <= n_armed;
            r_start_vld  <= n_start_vld;
            r_start_time <= n_start_time;
            r_last_vld   <= n_last_vld;
            r_last_time  <= n_last_time;
            r_run        <= n_run;
        end
    end

endmodule

`default_nettype wire

[sv/scan_backoff_policy_top.sv]
// The policy takes one item per clock cycle with no stalls of its own: each
// transfer is captured in an input register, decided by one pass of
// subtract-and-compare logic on the window state when the result register can
// take it, and held in a result register until the sink takes it. The only
// thing that slows the input is a result register that the sink does not take.
// Configuration writes take effect at once and should be made while idle.
// ----------------------------------------------------------------------------
// scan_backoff_policy_top
// Polling scheduler with backoff interval, lifetime expiry and empty-scan limit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scan_backoff_policy_top_assert.svh"

module scan_backoff_policy_top import sbp_pkg::*; #(
    parameter int TIME_BITS = 48
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CFG_IDXW-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]    i_cfg_data,
    sbp_in_if.sink                   i_in,
    sbp_out_if.source                o_out
);

    logic       r_in_vld;
    t_item      r_in_item;
    logic       r_out_vld;
    logic [1:0] r_out_verdict;
    logic       r_out_armed;

    logic       w_adv;
    logic       w_step;
    t_result    w_result;

    assign w_adv      = !r_out_vld || o_out.ready;
    assign w_step     = r_in_vld && w_adv;
    assign i_in.ready = !r_in_vld || w_adv;

    assign o_out.valid   = r_out_vld;
    assign o_out.verdict = r_out_verdict;
    assign o_out.armed   = r_out_armed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item.mode         <= i_in.mode;
            r_in_item.now_ms       <= i_in.now_ms;
            r_in_item.seen_count   <= i_in.seen_count;
            r_in_item.follow_count <= i_in.follow_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_verdict <= w_result.verdict;
            r_out_armed   <= w_result.armed;
        end
    end

    sbp_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (w_step),
        .i_item     (r_in_item),
        .o_result   (w_result)
    );

    `SBP_ASSERT_NEXT(a_step_gives_result, w_step, r_out_vld, "item decided but no result held")
    `SBP_ASSERT_NEXT(a_suspend_disarms, w_step && (r_in_item.mode == MODE_SUSPEND),
                     !r_out_armed, "suspend left the policy armed")
    `SBP_ASSERT_NEXT(a_request_arms, w_step && (r_in_item.mode == MODE_REQUEST),
                     r_out_armed, "request left the policy disarmed")
    `SBP_ASSERT_NOW(a_empty_stage_ready, !r_in_vld, i_in.ready,
                    "empty input register refused a transfer")

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the scan backoff policy. Items are sent over the input
// channel in bursts with random gaps while the result sink stalls on its own
// pattern. A behavioral copy of the policy computes the verdict and armed flag
// of every accepted item, and each result is checked against the oldest one.
// Directed cases come first, then random scan sessions under several settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench;
    import sbp_pkg::*;

    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_ITEMS  = 200;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_IDXW-1:0] i_cfg_idx;
    logic [CFG_W-1:0]    i_cfg_data;

    sbp_in_if  in_ch ();
    sbp_out_if out_ch ();

    scan_backoff_policy_top #(
        .TIME_BITS(48)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    logic [CFG_W-1:0] cfg_lifetime;
    logic [CFG_W-1:0] cfg_backoff_after;
    logic [CFG_W-1:0] cfg_normal_ival;
    logic [CFG_W-1:0] cfg_backoff_ival;
    logic [RUN_W-1:0] cfg_max_empty;

    logic             pol_armed;
    logic             pol_start_ok;
    logic [NOW_W-1:0] pol_start_ms;
    logic             pol_last_ok;
    logic [NOW_W-1:0] pol_last_ms;
    logic [RUN_W-1:0] pol_empty_run;

    t_result pending_results[$];
    int      n_sent;
    int      n_results;
    int      n_errors;
    int      burst_left;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    function automatic void drop_window();
        pol_empty_run = '0;
        pol_start_ok  = 1'b0;
        pol_start_ms  = '0;
        pol_last_ok   = 1'b0;
        pol_last_ms   = '0;
    endfunction

    function automatic void disarm_policy();
        pol_armed = 1'b0;
        drop_window();
    endfunction

    function automatic t_result predict_policy(input t_item it);
        t_result          r;
        logic [NOW_W-1:0] age;
        logic [NOW_W-1:0] ival;
        r.verdict = V_IDLE;
        case (it.mode)
            MODE_REQUEST: begin
                if (!pol_armed) begin
                    pol_armed = 1'b1;
                    drop_window();
                end
            end
            MODE_SUSPEND: begin
                disarm_policy();
            end
            MODE_EVALUATE: begin
                if (!pol_armed) begin
                    r.verdict = V_IDLE;
                end else if (!pol_start_ok || it.now_ms < pol_start_ms ||
                             (pol_last_ok && it.now_ms < pol_last_ms)) begin
                    pol_start_ok  = 1'b1;
                    pol_start_ms  = it.now_ms;
                    pol_last_ok   = 1'b1;
                    pol_last_ms   = it.now_ms;
                    pol_empty_run = '0;
                    r.verdict     = V_SCAN;
                end else begin
                    age = it.now_ms - pol_start_ms;
                    if (age >= NOW_W'(cfg_lifetime)) begin
                        disarm_policy();
                        r.verdict = V_EXPIRED;
                    end else begin
                        ival = (age >= NOW_W'(cfg_backoff_after)) ?
                               NOW_W'(cfg_backoff_ival) : NOW_W'(cfg_normal_ival);
                        if (!pol_last_ok || it.now_ms - pol_last_ms >= ival) begin
                            pol_last_ok = 1'b1;
                            pol_last_ms = it.now_ms;
                            r.verdict   = V_SCAN;
                        end else begin
                            r.verdict = V_WAIT;
                        end
                    end
                end
            end
            default: begin
                if (!pol_armed) begin
                    r.verdict = O_SETTLED;
                end else if (it.seen_count == '0) begin
                    if (pol_empty_run != 8'hFF) begin
                        pol_empty_run = pol_empty_run + 8'd1;
                    end
                    if (pol_empty_run >= cfg_max_empty) begin
                        disarm_policy();
                        r.verdict = O_NONE;
                    end else begin
                        r.verdict = O_CONTINUE;
                    end
                end else begin
                    pol_empty_run = '0;
                    if (it.follow_count == '0) begin
                        disarm_policy();
                        r.verdict = O_SETTLED;
                    end else begin
                        r.verdict = O_CONTINUE;
                    end
                end
            end
        endcase
        r.armed = pol_armed;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("[%0t] mismatch: %s, expected %0d, got %0d", $realtime, what, want, got);
        n_errors++;
    endtask

    // Results are checked before the new transfer is predicted, so a result can
    // never be matched with an item accepted at the same edge.
    always @(posedge i_clk) begin : result_checker
        t_result want;
        t_item   taken;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                n_results++;
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no transfer pending", 0,
                                    int'(out_ch.verdict));
                end else begin
                    want = pending_results.pop_front();
                    if (out_ch.verdict !== want.verdict) begin
                        report_mismatch("verdict", int'(want.verdict), int'(out_ch.verdict));
                    end
                    if (out_ch.armed !== want.armed) begin
                        report_mismatch("armed", int'(want.armed), int'(out_ch.armed));
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                taken.mode         = in_ch.mode;
                taken.now_ms       = in_ch.now_ms;
                taken.seen_count   = in_ch.seen_count;
                taken.follow_count = in_ch.follow_count;
                pending_results.push_back(predict_policy(taken));
            end
        end
    end

    initial begin : sink_stalls
        int seg_len;
        int pattern;
        int tick;
        out_ch.ready <= 1'b0;
        tick = 0;
        forever begin
            seg_len = $urandom_range(20, 200);
            pattern = $urandom_range(0, 3);
            repeat (seg_len) begin
                @(posedge i_clk);
                tick++;
                case (pattern)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= (tick % 6 == 5);
                endcase
            end
        end
    end

    function automatic t_item item_of(input logic [1:0] mode, input logic [NOW_W-1:0] t,
                                      input logic [CNT_W-1:0] seen,
                                      input logic [CNT_W-1:0] follow);
        t_item it;
        it.mode         = mode;
        it.now_ms       = t;
        it.seen_count   = seen;
        it.follow_count = follow;
        return it;
    endfunction

    function automatic logic [NOW_W-1:0] rand_time();
        logic [NOW_W-1:0] v;
        v[47:32] = 16'($urandom());
        v[31:0]  = $urandom();
        return v;
    endfunction

    function automatic logic [CNT_W-1:0] rand16();
        return 16'($urandom());
    endfunction

    function automatic int unsigned cap_span(input logic [CFG_W-1:0] x);
        return (x > 100000) ? 100000 : x;
    endfunction

    function automatic logic [NOW_W-1:0] step_ms();
        case ($urandom_range(0, 9))
            0: return '0;
            1, 2, 3, 4, 5: return NOW_W'($urandom_range(0, cap_span(cfg_normal_ival) * 3 / 2 + 1));
            6, 7: return NOW_W'($urandom_range(0, cap_span(cfg_backoff_ival) * 2 + 1));
            8: return NOW_W'($urandom_range(0, cap_span(cfg_lifetime) + 1));
            default: return NOW_W'($urandom());
        endcase
    endfunction

    function automatic logic [NOW_W-1:0] session_start();
        case ($urandom_range(0, 3))
            0: return NOW_W'($urandom_range(0, 100000));
            1: return 48'hFFFF_FFFF_FFFF - NOW_W'($urandom_range(0, 200000));
            default: return rand_time();
        endcase
    endfunction

    task automatic send_item(input t_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= it.mode;
        in_ch.now_ms       <= it.now_ms;
        in_ch.seen_count   <= it.seen_count;
        in_ch.follow_count <= it.follow_count;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (n_results < n_sent) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] lifetime,
                              input logic [CFG_W-1:0] backoff_after,
                              input logic [CFG_W-1:0] normal_ival,
                              input logic [CFG_W-1:0] backoff_ival,
                              input logic [RUN_W-1:0] max_empty);
        logic [CFG_IDXW-1:0] idx[5];
        logic [CFG_W-1:0]    val[5];
        idx[0] = CFG_MAX_LIFETIME;  val[0] = lifetime;
        idx[1] = CFG_BACKOFF_AFTER; val[1] = backoff_after;
        idx[2] = CFG_NORMAL_IVAL;   val[2] = normal_ival;
        idx[3] = CFG_BACKOFF_IVAL;  val[3] = backoff_ival;
        idx[4] = CFG_MAX_EMPTY;     val[4] = {24'd0, max_empty};
        for (int i = 0; i < 5; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[i];
            i_cfg_data <= val[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cfg_lifetime      = lifetime;
        cfg_backoff_after = backoff_after;
        cfg_normal_ival   = normal_ival;
        cfg_backoff_ival  = backoff_ival;
        cfg_max_empty     = max_empty;
    endtask

    task automatic test_directed();
        send_item(item_of(MODE_OBSERVE, '0, 16'd0, 16'd0));
        send_item(item_of(MODE_EVALUATE, 48'd500, 16'd0, 16'd0));
        send_item(item_of(MODE_REQUEST, '0, 16'd0, 16'd0));
        send_item(item_of(MODE_REQUEST, '1, 16'hFFFF, 16'hFFFF));
        send_item(item_of(MODE_EVALUATE, 48'd100, 16'd0, 16'd0));
        send_item(item_of(MODE_EVALUATE, 48'd600, 16'd0, 16'd0));
        send_item(item_of(MODE_EVALUATE, 48'd1100, 16'd0, 16'd0));
        send_item(item_of(MODE_EVALUATE, 48'd1050, 16'd0, 16'd0));
        send_item(item_of(MODE_EVALUATE, 48'd12000, 16'd0, 16'd0));
        send_item(item_of(MODE_EVALUATE, 48'd14000, 16'd0, 16'd0));
        send_item(item_of(MODE_OBSERVE, '0, 16'd0, 16'd7));
        send_item(item_of(MODE_OBSERVE, '0, 16'd0, 16'd0));
        send_item(item_of(MODE_OBSERVE, '0, 16'd5, 16'd3));
        repeat (3) send_item(item_of(MODE_OBSERVE, '0, 16'd0, 16'hFFFF));
        send_item(item_of(MODE_REQUEST, '0, 16'd0, 16'd0));
        send_item(item_of(MODE_EVALUATE, 48'hFFFF_FFFF_FFF5, 16'd0, 16'd0));
        send_item(item_of(MODE_EVALUATE, 48'hFFFF_FFFF_FFFF, 16'd0, 16'd0));
        send_item(item_of(MODE_OBSERVE, '0, 16'hFFFF, 16'd0));
        send_item(item_of(MODE_REQUEST, '0, 16'd0, 16'd0));
        send_item(item_of(MODE_EVALUATE, 48'd0, 16'd0, 16'd0));
        send_item(item_of(MODE_EVALUATE, 48'd60000, 16'd0, 16'd0));
        send_item(item_of(MODE_REQUEST, '0, 16'd0, 16'd0));
        send_item(item_of(MODE_SUSPEND, '1, 16'hFFFF, 16'hFFFF));
        send_item(item_of(MODE_OBSERVE, '1, 16'hFFFF, 16'hFFFF));
    endtask

    task automatic test_zero_limits();
        wait_idle();
        set_config('0, '0, '0, '0, '0);
        send_item(item_of(MODE_REQUEST, '0, 16'd0, 16'd0));
        send_item(item_of(MODE_EVALUATE, 48'd5, 16'd0, 16'd0));
        send_item(item_of(MODE_EVALUATE, 48'd5, 16'd0, 16'd0));
        send_item(item_of(MODE_REQUEST, '0, 16'd0, 16'd0));
        send_item(item_of(MODE_OBSERVE, '0, 16'd9, 16'd2));
        send_item(item_of(MODE_OBSERVE, '0, 16'd0, 16'd2));
        send_item(item_of(MODE_REQUEST, '0, 16'd0, 16'd0));
        send_item(item_of(MODE_EVALUATE, 48'd77, 16'd0, 16'd0));
        send_item(item_of(MODE_EVALUATE, 48'd78, 16'd0, 16'd0));
    endtask

    task automatic test_empty_limit();
        wait_idle();
        set_config('1, '1, '0, '0, 8'd255);
        send_item(item_of(MODE_REQUEST, rand_time(), rand16(), rand16()));
        send_item(item_of(MODE_EVALUATE, 48'd1000, rand16(), rand16()));
        repeat (255) send_item(item_of(MODE_OBSERVE, rand_time(), 16'd0, rand16()));
        send_item(item_of(MODE_EVALUATE, 48'd2000, rand16(), rand16()));
    endtask

    task automatic run_sessions(input int count);
        int               sent_here;
        int               steps;
        int               pick;
        logic [NOW_W-1:0] t;
        logic [CNT_W-1:0] seen;
        logic [CNT_W-1:0] follow;
        sent_here = 0;
        while (sent_here < count) begin
            t = session_start();
            send_item(item_of(MODE_REQUEST, rand_time(), rand16(), rand16()));
            sent_here++;
            steps = $urandom_range(4, 40);
            repeat (steps) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    t = t + step_ms();
                    send_item(item_of(MODE_EVALUATE, t, rand16(), rand16()));
                end else if (pick < 92) begin
                    seen   = ($urandom_range(0, 2) != 0) ? 16'd0 :
                             ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 4)) : rand16();
                    follow = ($urandom_range(0, 2) == 0) ? 16'd0 : rand16();
                    send_item(item_of(MODE_OBSERVE, rand_time(), seen, follow));
                end else if (pick < 95) begin
                    send_item(item_of(MODE_REQUEST, rand_time(), rand16(), rand16()));
                end else begin
                    send_item(item_of(2'($urandom_range(0, 3)), rand_time(), rand16(),
                                      rand16()));
                end
                sent_here++;
            end
            if ($urandom_range(0, 1) != 0) begin
                send_item(item_of(MODE_SUSPEND, rand_time(), rand16(), rand16()));
                sent_here++;
            end
        end
    endtask

    task automatic test_random_configs();
        logic [CFG_W-1:0] lt;
        logic [CFG_W-1:0] ba;
        logic [CFG_W-1:0] ni;
        logic [CFG_W-1:0] bi;
        logic [RUN_W-1:0] me;
        for (int phase = 0; phase < 7; phase++) begin
            lt = $urandom_range(1, 20000);
            ba = $urandom_range(0, lt);
            ni = $urandom_range(0, 1500);
            bi = $urandom_range(ni, 4000);
            me = 8'($urandom_range(1, 6));
            case (phase)
                0: begin
                    lt = RST_MAX_LIFETIME;
                    ba = RST_BACKOFF_AFTER;
                    ni = RST_NORMAL_IVAL;
                    bi = RST_BACKOFF_IVAL;
                    me = RST_MAX_EMPTY;
                end
                2: begin
                    lt = '1;
                    ba = '1;
                    ni = '1;
                    bi = '1;
                    me = 8'hFF;
                end
                3: begin
                    lt = 32'd1;
                    ba = '0;
                    ni = '0;
                    bi = '0;
                    me = 8'd1;
                end
                4: begin
                    ba = lt + $urandom_range(0, 1000);
                end
                5: begin
                    lt = $urandom();
                    ba = $urandom();
                    ni = $urandom();
                    bi = $urandom();
                    me = 8'($urandom_range(1, 255));
                end
                default: begin
                end
            endcase
            wait_idle();
            set_config(lt, ba, ni, bi, me);
            run_sessions(PHASE_ITEMS);
        end
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_MAX_LIFETIME;
        i_cfg_data         <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.mode         <= MODE_REQUEST;
        in_ch.now_ms       <= '0;
        in_ch.seen_count   <= '0;
        in_ch.follow_count <= '0;
        n_sent     = 0;
        n_results  = 0;
        n_errors   = 0;
        burst_left = 0;
        cfg_lifetime      = RST_MAX_LIFETIME;
        cfg_backoff_after = RST_BACKOFF_AFTER;
        cfg_normal_ival   = RST_NORMAL_IVAL;
        cfg_backoff_ival  = RST_BACKOFF_IVAL;
        cfg_max_empty     = RST_MAX_EMPTY;
        disarm_policy();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_zero_limits();
        test_empty_limit();
        test_random_configs();
        wait_idle();

        if (pending_results.size() != 0) begin
            report_mismatch("results still pending at end", 0, pending_results.size());
        end
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
